[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/lpr_pkg.sv]
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the LRU replacement cell row and its control.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // Widest supported frame row, sizes the index and rank fields
    localparam int MAX_FRAMES = 64;
    localparam int IDX_W      = 6;
    localparam int PAGE_W     = 16;
    localparam int FIDX_W     = 3;
    localparam int CFG_W      = 4;
    localparam int COUNT_W    = 16;

    localparam logic [COUNT_W-1:0] FAULT_MAX  = '1;
    localparam logic [CFG_W-1:0]   CFG_RESET  = CFG_W'(8);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [IDX_W-1:0] t_rank;

    // Search result carried from cell to cell
    typedef struct packed {
        logic  hit;
        t_idx  hit_idx;
        t_rank hit_rank;
        logic  free;
        t_idx  free_idx;
        t_rank old_rank;
        t_idx  old_idx;
    } t_srch;

    // Commit command broadcast to every cell
    typedef struct packed {
        logic  en;
        logic  clear;
        logic  miss;
        t_idx  used;
        t_rank limit;
    } t_upd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

endpackage

[sv/lru_page_replacement.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page replacement over a row of frame cells.
// ----------------------------------------------------------------------------
// One item is in flight at a time. After an item is accepted a search token
// walks the row of FRAMES cells, one cell per cycle, picking up the lowest
// hit, the lowest free frame and the oldest frame; the finish state then
// commits the choice to every cell and loads the output register, waiting
// while that register still holds a result that has not been taken. A new
// item is accepted as soon as the row is free, even while the previous
// result still waits in the output register.
// frames_in_use may be written only while the block is idle.
`include "assert_macros.svh"

module lru_page_replacement import lpr_pkg::*; #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic               i_last_ref,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_fault,
    output logic [FIDX_W-1:0]  o_frame_index,
    output logic [COUNT_W-1:0] o_fault_total,
    output logic               o_string_done,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_frames_in_use
);

    localparam int SW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

    t_state             r_state;
    t_state             n_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [SW-1:0]      r_page;
    logic               r_last;
    logic               r_start;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_out_valid;
    logic               r_fault;
    logic [FIDX_W-1:0]  r_frame_index;
    logic [COUNT_W-1:0] r_fault_total;
    logic               r_string_done;

    logic [FRAMES:0]    w_tok;
    t_srch              w_srch [FRAMES+1];
    logic [FRAMES-1:0]  w_in_set;
    t_srch              w_fin;
    t_idx               w_used;
    t_upd               w_upd;
    logic               w_fire;
    logic               w_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_frames_in_use;
        end
    end

    // Zero frames counts as one; above FRAMES the whole row is in use
    genvar g;
    generate
        for (g = 0; g < FRAMES; g++) begin : g_row
            assign w_in_set[g] = (g == 0) || (g < int'(r_cfg));

            lpr_cell #(
                .IDX    (g),
                .FRAMES (FRAMES),
                .SW     (SW)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_in_set (w_in_set[g]),
                .i_page   (r_page),
                .i_tok    (w_tok[g]),
                .i_srch   (w_srch[g]),
                .o_tok    (w_tok[g+1]),
                .o_srch   (w_srch[g+1]),
                .i_upd    (w_upd)
            );
        end
    endgenerate

    assign w_tok[0]  = r_start;
    assign w_srch[0] = '0;
    assign w_fin     = w_srch[FRAMES];

    always_comb begin
        if (w_fin.hit) begin
            w_used = w_fin.hit_idx;
        end else if (w_fin.free) begin
            w_used = w_fin.free_idx;
        end else begin
            w_used = w_fin.old_idx;
        end
        if (w_fin.hit || r_count == FAULT_MAX) begin
            n_count = r_count;
        end else begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    assign w_upd.en    = w_fire;
    assign w_upd.clear = r_last;
    assign w_upd.miss  = !w_fin.hit;
    assign w_upd.used  = w_used;
    assign w_upd.limit = w_fin.hit_rank;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_fire     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_tok[FRAMES]) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold the search result until the output slot is free
                if (!r_out_valid || i_out_ready) begin
                    w_fire  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept;
            if (w_fire) begin
                r_count     <= r_last ? '0 : n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= i_page[SW-1:0];
            r_last <= i_last_ref;
        end
        if (w_fire) begin
            r_fault       <= !w_fin.hit;
            r_frame_index <= w_used[FIDX_W-1:0];
            r_fault_total <= n_count;
            r_string_done <= r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fault       = r_fault;
    assign o_frame_index = r_frame_index;
    assign o_fault_total = r_fault_total;
    assign o_string_done = r_string_done;

    `ASSERT_CLK(a_single_token, $onehot0(w_tok), "more than one search token in the row")
    `ASSERT_CLK(a_token_in_search, w_tok[FRAMES] |-> r_state == S_SEARCH,
        "search token left the row outside a search")
    `ASSERT_CLK(a_finish_delivers, (r_state == S_FINISH && !r_out_valid) |=>
        (o_out_valid && r_state == S_IDLE), "finished search did not deliver its item")
    `ASSERT_CLK(a_used_in_row, w_fire |-> int'(w_used) < FRAMES,
        "chosen frame lies outside the row")

endmodule

[sv/lpr_cell.sv]
// ----------------------------------------------------------------------------
// lpr_cell
// One frame of the row: holds page, valid and recency rank, folds its frame
// into the search result passing by and applies the broadcast commit.
// ----------------------------------------------------------------------------
module lpr_cell import lpr_pkg::*; #(
    parameter int IDX    = 0,
    parameter int FRAMES = 8,
    parameter int SW     = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_set,
    input  logic [SW-1:0] i_page,
    input  logic          i_tok,
    input  t_srch         i_srch,
    output logic          o_tok,
    output t_srch         o_srch,
    input  t_upd          i_upd
);

    localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam t_idx          MY_IDX   = t_idx'(IDX);
    localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);

    logic [SW-1:0] r_page;
    logic          r_valid;
    logic [RW-1:0] r_rank;
    logic          r_tok;
    t_srch         r_srch;
    t_srch         n_srch;
    t_rank         w_rank;

    assign w_rank = t_rank'(r_rank);

    always_comb begin
        n_srch = i_srch;
        if (i_in_set) begin
            if (r_valid && (r_page == i_page) && !i_srch.hit) begin
                n_srch.hit      = 1'b1;
                n_srch.hit_idx  = MY_IDX;
                n_srch.hit_rank = w_rank;
            end
            if (!r_valid && !i_srch.free) begin
                n_srch.free     = 1'b1;
                n_srch.free_idx = MY_IDX;
            end
            // strictly older wins, so ties keep the lower frame
            if (w_rank > i_srch.old_rank) begin
                n_srch.old_rank = w_rank;
                n_srch.old_idx  = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
        if (i_tok) begin
            r_srch <= n_srch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en) begin
            if (i_upd.clear) begin
                r_valid <= 1'b0;
                r_rank  <= '0;
            end else if (i_upd.used == MY_IDX) begin
                r_rank <= '0;
                if (i_upd.miss) begin
                    r_valid <= 1'b1;
                end
            end else if (i_in_set && r_valid && (i_upd.miss || w_rank < i_upd.limit)
                         && r_rank != RANK_MAX) begin
                r_rank <= r_rank + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.clear) begin
            r_page <= '0;
        end else if (i_upd.en && i_upd.miss && i_upd.used == MY_IDX) begin
            r_page <= i_page;
        end
    end

    assign o_tok  = r_tok;
    assign o_srch = r_srch;

endmodule

[tb/sv/lru_page_replacement_checker.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement_checker
// Watches the reference, result and working-set channels of the LRU page
// replacement block, predicts every result and compares it with what leaves.
// ----------------------------------------------------------------------------
module lru_page_replacement_checker import lpr_pkg::*; #(
    parameter int FRAMES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic               i_last_ref,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_fault,
    input  logic [FIDX_W-1:0]  i_frame_index,
    input  logic [COUNT_W-1:0] i_fault_total,
    input  logic               i_string_done,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_frames_in_use,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_faults,
    output int                 o_strings,
    output int                 o_saturated
);

    localparam int RANK_W = $clog2(FRAMES);

    typedef struct packed {
        logic               fault;
        logic [FIDX_W-1:0]  frame;
        logic [COUNT_W-1:0] total;
        logic               done;
    } t_ref_outcome;

    logic [PAGE_W-1:0]  frame_tag  [FRAMES];
    logic               frame_live [FRAMES];
    logic [RANK_W-1:0]  frame_age  [FRAMES];
    logic [COUNT_W-1:0] string_faults = '0;
    logic [CFG_W-1:0]   set_size = CFG_RESET;

    t_ref_outcome awaited_outcomes [$];

    int err_count  = 0;
    int seen_count = 0;
    int miss_count = 0;
    int done_count = 0;
    int ceil_count = 0;

    initial o_pending = 0;

    assign o_errors    = err_count;
    assign o_results   = seen_count;
    assign o_faults    = miss_count;
    assign o_strings   = done_count;
    assign o_saturated = ceil_count;

    task automatic clear_frames();
        int i;
        for (i = 0; i < FRAMES; i++) begin
            frame_tag[i]  = '0;
            frame_live[i] = 1'b0;
            frame_age[i]  = '0;
        end
        string_faults = '0;
    endtask

    // Age live frames of the working set that are younger than limit.
    task automatic age_frames(input int n, input int limit);
        int i;
        for (i = 0; i < n; i++) begin
            if (frame_live[i] && frame_age[i] < limit && frame_age[i] < FRAMES - 1)
                frame_age[i] = frame_age[i] + 1'b1;
        end
    endtask

    task automatic resolve_reference(input logic [PAGE_W-1:0] pg, input logic last,
                                     output t_ref_outcome res);
        int  n;
        int  i;
        int  used;
        int  free_idx;
        int  oldest;
        bit  hit;
        bit  have_free;
        n         = set_size;
        used      = 0;
        free_idx  = 0;
        hit       = 1'b0;
        have_free = 1'b0;
        if (n < 1)
            n = 1;
        if (n > FRAMES)
            n = FRAMES;
        // lowest matching frame wins
        for (i = 0; i < n; i++) begin
            if (!hit && frame_live[i] && frame_tag[i] == pg) begin
                hit  = 1'b1;
                used = i;
            end
        end
        if (!hit) begin
            for (i = 0; i < n; i++) begin
                if (!have_free && !frame_live[i]) begin
                    have_free = 1'b1;
                    free_idx  = i;
                end
            end
        end
        if (hit) begin
            age_frames(n, frame_age[used]);
            frame_age[used] = '0;
        end else if (have_free) begin
            used = free_idx;
            age_frames(n, 256);
            frame_live[used] = 1'b1;
            frame_tag[used]  = pg;
            frame_age[used]  = '0;
        end else begin
            // strictly greater keeps the lowest index on a tie
            oldest = 0;
            for (i = 0; i < n; i++) begin
                if (frame_age[i] > oldest) begin
                    oldest = frame_age[i];
                    used   = i;
                end
            end
            age_frames(n, 256);
            frame_tag[used] = pg;
            frame_age[used] = '0;
        end
        if (!hit && string_faults != FAULT_MAX)
            string_faults = string_faults + 1'b1;
        res.fault = !hit;
        res.frame = used[FIDX_W-1:0];
        res.total = string_faults;
        res.done  = last;
        if (last)
            clear_frames();
    endtask

    initial clear_frames();

    always @(posedge i_clk) begin
        t_ref_outcome want;
        t_ref_outcome got;
        if (!i_rst_n) begin
            clear_frames();
            set_size = CFG_RESET;
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                set_size = i_cfg_frames_in_use;
            if (i_out_valid && i_out_ready) begin
                got.fault = i_fault;
                got.frame = i_frame_index;
                got.total = i_fault_total;
                got.done  = i_string_done;
                seen_count++;
                if (got.fault === 1'b1)
                    miss_count++;
                if (got.done === 1'b1)
                    done_count++;
                if (got.total === FAULT_MAX)
                    ceil_count++;
                if (awaited_outcomes.size() == 0) begin
                    if (err_count < 10)
                        $display("result %0d arrived with nothing outstanding", seen_count);
                    err_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (got.fault !== want.fault || got.frame !== want.frame ||
                        got.total !== want.total || got.done !== want.done) begin
                        if (err_count < 10) begin
                            $display("result %0d: expected fault=%0b frame=%0d total=%0d done=%0b",
                                     seen_count, want.fault, want.frame, want.total,
                                     want.done);
                            $display("    got fault=%0b frame=%0d total=%0d done=%0b",
                                     got.fault, got.frame, got.total, got.done);
                        end
                        err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                resolve_reference(i_page, i_last_ref, want);
                awaited_outcomes.push_back(want);
            end
        end
        o_pending <= awaited_outcomes.size();
    end

endmodule

[tb/sv/lru_page_replacement_test.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement_test
// Drives page references and working-set sizes into the LRU replacement
// block with random gaps and stalls; a side checker predicts every result.
// ----------------------------------------------------------------------------
module lru_page_replacement_test;
    import lpr_pkg::*;

    localparam int FRAMES          = 8;
    localparam int LATENCY         = FRAMES + 2;
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int RANDOM_REFS     = 400;
    localparam int RANDOM_PHASES   = 8;
    localparam int HOLD_CYCLES     = 300;

    logic               clk               = 1'b0;
    logic               rst_n             = 1'b0;
    logic               in_valid          = 1'b0;
    logic               in_ready;
    logic [PAGE_W-1:0]  page              = '0;
    logic               last_ref          = 1'b0;
    logic               out_valid;
    logic               out_ready         = 1'b0;
    logic               fault;
    logic [FIDX_W-1:0]  frame_index;
    logic [COUNT_W-1:0] fault_total;
    logic               string_done;
    logic               cfg_valid         = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_frames_in_use = CFG_RESET;

    int errors;
    int pending;
    int results;
    int faults;
    int strings;
    int saturated;

    int cycle_count = 0;
    int refs_sent   = 0;
    int cfg_writes  = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;

    lru_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_W)
    ) dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_page              (page),
        .i_last_ref          (last_ref),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_fault             (fault),
        .o_frame_index       (frame_index),
        .o_fault_total       (fault_total),
        .o_string_done       (string_done),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_frames_in_use (cfg_frames_in_use)
    );

    lru_page_replacement_checker #(
        .FRAMES (FRAMES)
    ) lru_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_page              (page),
        .i_last_ref          (last_ref),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_fault             (fault),
        .i_frame_index       (frame_index),
        .i_fault_total       (fault_total),
        .i_string_done       (string_done),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_frames_in_use (cfg_frames_in_use),
        .o_errors            (errors),
        .o_pending           (pending),
        .o_results           (results),
        .o_faults            (faults),
        .o_strings           (strings),
        .o_saturated         (saturated)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("lru_page_replacement_test: FAIL");
            $finish;
        end
    end

    // Mostly short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic last);
        int gap;
        in_valid <= 1'b1;
        page     <= pg;
        last_ref <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        refs_sent++;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let every outstanding result leave, then allow the row to settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_set_size(input logic [CFG_W-1:0] size);
        drain();
        cfg_valid         <= 1'b1;
        cfg_frames_in_use <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly references from a small pool so hits and LRU victims occur.
    task automatic random_refs(input int count);
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] pg;
        int                pool;
        int                r;
        base = PAGE_W'($urandom);
        pool = $urandom_range(2, 12);
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                pg = base + PAGE_W'($urandom_range(0, pool - 1));
            end else if (r < 90) begin
                pg = PAGE_W'($urandom);
            end else if (r < 95) begin
                pg = $urandom_range(0, 1) ? '1 : '0;
            end else begin
                // move the locality window
                base = PAGE_W'($urandom);
                pool = $urandom_range(2, 12);
                pg   = base;
            end
            send_ref(pg, $urandom_range(0, 19) == 0);
        end
    endtask

    initial begin : receiver
        bit hold_done;
        int run;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                // hold off long enough for the block to back up its input
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (calm) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat (idle_len() + 1) @(posedge clk);
                run = idle_len();
                if (run > 0) begin
                    out_ready <= 1'b0;
                    repeat (run) @(posedge clk);
                end
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] set_val;
        int               i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset working set of eight: extremes, a hit, fill every frame, replace the LRU.
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0000, 1'b0);
        send_ref(16'h8000, 1'b0);
        for (i = 1; i <= 5; i++)
            send_ref(PAGE_W'(i), 1'b0);
        send_ref(16'h1234, 1'b0);
        send_ref(16'h0003, 1'b1);

        // Zero is taken as a single frame.
        write_set_size('0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'h5555, 1'b1);

        // Oversized value, then shrink and grow mid-string to leave a duplicate.
        write_set_size('1);
        for (i = 0; i < FRAMES; i++)
            send_ref(PAGE_W'(16'h0010 + i), 1'b0);
        write_set_size(CFG_W'(4));
        send_ref(16'h0015, 1'b0);
        write_set_size(CFG_W'(FRAMES));
        send_ref(16'h0015, 1'b0);
        send_ref(16'h0020, 1'b1);

        for (i = 0; i < RANDOM_PHASES; i++) begin
            case (i)
                0: begin
                    set_val = CFG_W'(1);
                end
                1: begin
                    set_val = CFG_W'(FRAMES);
                end
                default: begin
                    if ($urandom_range(0, 9) < 7)
                        set_val = CFG_W'($urandom_range(1, FRAMES));
                    else
                        set_val = CFG_W'($urandom_range(0, 15));
                end
            endcase
            calm <= (i == 5);
            write_set_size(set_val);
            if (i == 3)
                hold_req <= 1'b1;
            random_refs(RANDOM_REFS / RANDOM_PHASES);
        end

        drain();

        $display("%0d references checked: %0d faults, %0d hits, %0d strings closed",
                 results, faults, results - faults, strings);
        $display("%0d working-set writes; fault count at its ceiling on %0d results",
                 cfg_writes, saturated);
        if (errors == 0 && pending == 0)
            $display("lru_page_replacement_test: PASS");
        else
            $display("lru_page_replacement_test: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/lpr_pkg.sv
sv/lpr_cell.sv
sv/lru_page_replacement.sv
tb/sv/lru_page_replacement_checker.sv
tb/sv/lru_page_replacement_test.sv
